>>> rtl/rlp_pkg.sv
// rlp_pkg: shared widths, character codes and register indexes
// for the resolution line parser. No dependencies.
package rlp_pkg;

    localparam int BYTE_W    = 8;
    localparam int DIM_W     = 16;
    localparam int ACC_W     = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [DIM_W-1:0]     t_dim;
    typedef logic [ACC_W-1:0]     t_acc;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_byte CH_NUL   = 8'h00;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_COMMA = 8'h2C;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_UX    = 8'h58;
    localparam t_byte CH_LX    = 8'h78;

    localparam t_cfg_idx REG_MAX_WIDTH  = 2'd0;
    localparam t_cfg_idx REG_MAX_HEIGHT = 2'd1;
    localparam t_cfg_idx REG_MIN_WIDTH  = 2'd2;
    localparam t_cfg_idx REG_MIN_HEIGHT = 2'd3;

    localparam t_dim RST_MAX_WIDTH  = 16'd1920;
    localparam t_dim RST_MAX_HEIGHT = 16'd1200;
    localparam t_dim RST_MIN_WIDTH  = 16'd320;
    localparam t_dim RST_MIN_HEIGHT = 16'd200;

endpackage

>>> rtl/rlp_ifs.sv
// rlp_ifs: valid/ready channel interfaces for received bytes, parse results
// and register writes. Depends on rlp_pkg.
interface rlp_rx_if import rlp_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rlp_res_if import rlp_pkg::*;;
    logic valid;
    logic ready;
    logic line_end;
    logic line_ok;
    t_dim out_width;
    t_dim out_height;

    modport source (output valid, output line_end, output line_ok,
                    output out_width, output out_height, input ready);
    modport sink   (input valid, input line_end, input line_ok,
                    input out_width, input out_height, output ready);
endinterface

interface rlp_cfg_if import rlp_pkg::*;;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_dim     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/resolution_line_parser.sv
// resolution_line_parser: parses "W x H" text lines from a byte stream.
// Result path: input register, then parse logic into the result register;
// the input register holds while the result is not taken. Throughput: one
// byte per cycle while the sink is ready, with a combinational multiply-by-ten
// accumulator update. Reset (synchronous, active low) clears both stages, the
// line state and loads the default clamp bounds. Depends on rlp_pkg and rlp_ifs.
module resolution_line_parser
    import rlp_pkg::*;
#(
    parameter int LINE_CHARS = 28
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rlp_rx_if.sink     i_rx,
    rlp_cfg_if.sink    i_cfg,
    rlp_res_if.source  o_res
);

    localparam int CNT_W = $clog2(LINE_CHARS);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_CHARS - 1);

    typedef enum logic [2:0] {
        PH_LEAD, PH_WDIG, PH_SEP, PH_HDIG, PH_DONE, PH_FAIL
    } t_phase;

    // clamp bounds
    t_dim r_max_w, r_max_h, r_min_w, r_min_h;

    // input stage
    logic  r_in_valid;
    t_byte r_in_byte;

    // line state
    t_phase           r_phase, n_phase;
    t_acc             r_wacc, n_wacc;
    t_acc             r_hacc, n_hacc;
    logic [CNT_W-1:0] r_count, n_count;

    // result stage
    logic r_out_valid;
    logic r_end, n_end;
    logic r_ok, n_ok;
    t_dim r_w, n_w;
    t_dim r_h, n_h;

    logic       adv;
    t_byte      c;
    logic       is_digit, is_blank, is_sep;
    logic [3:0] digit;
    t_acc       w_mul, h_mul;

    function automatic t_dim clamp_even(input t_acc v, input t_dim hi, input t_dim lo);
        t_dim t;
        t = (v > {{(ACC_W-DIM_W){1'b0}}, hi}) ? hi : v[DIM_W-1:0];
        if (t < lo) t = lo;
        return {t[DIM_W-1:1], 1'b0};
    endfunction

    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready  = !r_in_valid || adv;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid      = r_out_valid;
    assign o_res.line_end   = r_end;
    assign o_res.line_ok    = r_ok;
    assign o_res.out_width  = r_w;
    assign o_res.out_height = r_h;

    assign c        = r_in_byte;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB);
    assign is_sep   = is_blank || (c == CH_LX) || (c == CH_UX) || (c == CH_COMMA);
    assign digit    = c[3:0];
    assign w_mul    = (r_wacc << 3) + (r_wacc << 1) + ACC_W'(digit);
    assign h_mul    = (r_hacc << 3) + (r_hacc << 1) + ACC_W'(digit);

    always_comb begin
        n_phase = r_phase;
        n_wacc  = r_wacc;
        n_hacc  = r_hacc;
        n_count = r_count;
        n_end   = 1'b0;
        n_ok    = 1'b0;
        n_w     = '0;
        n_h     = '0;
        if (c == CH_CR) begin
            // skipped
        end else if (c == CH_LF) begin
            n_end = 1'b1;
            if ((r_phase == PH_HDIG || r_phase == PH_DONE) &&
                r_wacc != '0 && r_hacc != '0) begin
                n_ok = 1'b1;
                n_w  = clamp_even(r_wacc, r_max_w, r_min_w);
                n_h  = clamp_even(r_hacc, r_max_h, r_min_h);
            end
            n_phase = PH_LEAD;
            n_wacc  = '0;
            n_hacc  = '0;
            n_count = '0;
        end else if (r_count < CNT_LIMIT) begin
            n_count = r_count + 1'b1;
            if (c == CH_NUL) begin
                if (r_phase == PH_HDIG) n_phase = PH_DONE;
                else if (r_phase != PH_DONE) n_phase = PH_FAIL;
            end else begin
                case (r_phase)
                    PH_LEAD: begin
                        if (is_digit) begin
                            n_wacc  = w_mul;
                            n_phase = PH_WDIG;
                        end else if (!is_blank) begin
                            n_phase = PH_FAIL;
                        end
                    end
                    PH_WDIG: begin
                        if (is_digit) n_wacc = w_mul;
                        else if (is_sep) n_phase = PH_SEP;
                        else n_phase = PH_FAIL;
                    end
                    PH_SEP: begin
                        if (is_digit) begin
                            n_hacc  = h_mul;
                            n_phase = PH_HDIG;
                        end else if (!is_sep) begin
                            n_phase = PH_FAIL;
                        end
                    end
                    PH_HDIG: begin
                        if (is_digit) n_hacc = h_mul;
                        else n_phase = PH_DONE;
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            // overlong line: drop byte, restart
            n_phase = PH_LEAD;
            n_wacc  = '0;
            n_hacc  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_w <= RST_MAX_WIDTH;
            r_max_h <= RST_MAX_HEIGHT;
            r_min_w <= RST_MIN_WIDTH;
            r_min_h <= RST_MIN_HEIGHT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MAX_WIDTH:  r_max_w <= i_cfg.data;
                REG_MAX_HEIGHT: r_max_h <= i_cfg.data;
                REG_MIN_WIDTH:  r_min_w <= i_cfg.data;
                REG_MIN_HEIGHT: r_min_h <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_wacc      <= '0;
            r_hacc      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_phase     <= n_phase;
            r_wacc      <= n_wacc;
            r_hacc      <= n_hacc;
            r_count     <= n_count;
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_end <= n_end;
            r_ok  <= n_ok;
            r_w   <= n_w;
            r_h   <= n_h;
        end
    end

endmodule

>>> test/tb_resolution_line_parser.sv
// tb_resolution_line_parser: self-checking bench for the "W x H" line parser.
// A directed byte table, then random lines checked against an in-bench parse
// predictor under bursty input and a stalling sink. Needs rlp_pkg and rlp_ifs.
module tb_resolution_line_parser;
    import rlp_pkg::*;

    localparam int LINE_CHARS = 28;
    localparam int DIR_ROWS   = 30;
    localparam int PHASES     = 6;
    localparam int PHASE_BYTES = 80;

    typedef enum logic [2:0] {
        SCAN_LEAD, SCAN_WIDTH, SCAN_GAP, SCAN_HEIGHT, SCAN_TAIL, SCAN_BAD
    } t_scan_phase;

    typedef struct packed {
        logic line_end;
        logic line_ok;
        t_dim width;
        t_dim height;
    } t_line_result;

    typedef struct packed {
        t_byte        ch;
        logic         fixed;
        t_line_result want;
    } t_stim_row;

    localparam t_line_result NO_LINE  = '0;
    localparam t_line_result REJECTED = '{1'b1, 1'b0, 16'd0, 16'd0};

    localparam t_stim_row DIRECTED [DIR_ROWS] = '{
        '{"9",      1'b1, NO_LINE},
        '{CH_LX,    1'b1, NO_LINE},
        '{"9",      1'b1, NO_LINE},
        '{CH_LF,    1'b1, '{1'b1, 1'b1, 16'd320, 16'd200}},
        '{CH_TAB,   1'b1, NO_LINE},
        '{"5",      1'b1, NO_LINE},
        '{"0",      1'b1, NO_LINE},
        '{"0",      1'b1, NO_LINE},
        '{"0",      1'b1, NO_LINE},
        '{CH_COMMA, 1'b1, NO_LINE},
        '{CH_CR,    1'b1, NO_LINE},
        '{"3",      1'b1, NO_LINE},
        '{"0",      1'b1, NO_LINE},
        '{"0",      1'b1, NO_LINE},
        '{"0",      1'b1, NO_LINE},
        '{CH_LF,    1'b1, '{1'b1, 1'b1, 16'd1920, 16'd1200}},
        '{"7",      1'b1, NO_LINE},
        '{CH_NUL,   1'b1, NO_LINE},
        '{CH_LF,    1'b1, REJECTED},
        '{8'hFF,    1'b1, NO_LINE},
        '{CH_LF,    1'b1, REJECTED},
        '{"0",      1'b1, NO_LINE},
        '{CH_UX,    1'b1, NO_LINE},
        '{"5",      1'b1, NO_LINE},
        '{CH_LF,    1'b1, REJECTED},
        '{"3",      1'b0, NO_LINE},
        '{CH_LX,    1'b0, NO_LINE},
        '{"4",      1'b0, NO_LINE},
        '{CH_NUL,   1'b0, NO_LINE},
        '{CH_LF,    1'b0, NO_LINE}
    };

    logic i_clk;
    logic i_rst_n;

    rlp_rx_if  rx ();
    rlp_cfg_if cfg ();
    rlp_res_if res ();

    resolution_line_parser #(.LINE_CHARS(LINE_CHARS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // predictor state
    t_scan_phase scan;
    t_acc        width_acc;
    t_acc        height_acc;
    int          line_len;
    t_dim        lim_max_w, lim_max_h, lim_min_w, lim_min_h;

    t_stim_row    byte_q [$];
    t_line_result awaited_lines [$];
    int           queued_bytes;
    int           results_seen;
    int           mismatch_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1600000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void clear_line();
        scan       = SCAN_LEAD;
        width_acc  = '0;
        height_acc = '0;
        line_len   = 0;
    endfunction

    function automatic t_dim clamp_even(t_acc v, t_dim hi, t_dim lo);
        t_acc c;
        c = v;
        if (c > t_acc'(hi)) c = t_acc'(hi);
        if (c < t_acc'(lo)) c = t_acc'(lo);
        return t_dim'(c & ~t_acc'(1));
    endfunction

    function automatic t_line_result parse_byte(t_byte c);
        t_line_result r;
        logic         dig, blank, sep;
        t_acc         dval;
        r     = NO_LINE;
        dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        blank = (c == CH_SPACE) || (c == CH_TAB);
        sep   = blank || (c == CH_LX) || (c == CH_UX) || (c == CH_COMMA);
        dval  = t_acc'(c) - t_acc'(CH_ZERO);
        if (c == CH_CR) return r;
        if (c == CH_LF) begin
            r.line_end = 1'b1;
            if ((scan == SCAN_HEIGHT || scan == SCAN_TAIL) &&
                width_acc != '0 && height_acc != '0) begin
                r.line_ok = 1'b1;
                r.width   = clamp_even(width_acc, lim_max_w, lim_min_w);
                r.height  = clamp_even(height_acc, lim_max_h, lim_min_h);
            end
            clear_line();
            return r;
        end
        if (line_len < LINE_CHARS - 1) begin
            line_len++;
            if (c == CH_NUL) begin
                if (scan == SCAN_HEIGHT) scan = SCAN_TAIL;
                else if (scan != SCAN_TAIL) scan = SCAN_BAD;
            end else begin
                case (scan)
                    SCAN_LEAD: begin
                        if (dig) begin
                            width_acc = width_acc * 10 + dval;
                            scan = SCAN_WIDTH;
                        end else if (!blank) begin
                            scan = SCAN_BAD;
                        end
                    end
                    SCAN_WIDTH: begin
                        if (dig) width_acc = width_acc * 10 + dval;
                        else if (sep) scan = SCAN_GAP;
                        else scan = SCAN_BAD;
                    end
                    SCAN_GAP: begin
                        if (dig) begin
                            height_acc = height_acc * 10 + dval;
                            scan = SCAN_HEIGHT;
                        end else if (!sep) begin
                            scan = SCAN_BAD;
                        end
                    end
                    SCAN_HEIGHT: begin
                        if (dig) height_acc = height_acc * 10 + dval;
                        else scan = SCAN_TAIL;
                    end
                    default: ;
                endcase
            end
        end else begin
            clear_line();
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d, %s: got %0d want %0d",
                 results_seen, what, got, want);
        mismatch_count++;
    endtask

    // ---------------- stimulus building ----------------
    function automatic void push_char(t_byte c);
        byte_q.push_back('{c, 1'b0, NO_LINE});
        queued_bytes++;
    endfunction

    function automatic t_byte pick_blank();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB;
    endfunction

    function automatic t_byte pick_sep();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LX;
            3:       return CH_UX;
            default: return CH_COMMA;
        endcase
    endfunction

    function automatic longint unsigned pick_size();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 9);
            1:       return $urandom_range(0, 3000);
            2:       return $urandom_range(0, 70000);
            default: return $urandom_range(60000, 99999);
        endcase
    endfunction

    function automatic longint unsigned pick_wrap();
        if ($urandom_range(0, 2) == 0) return 64'd4294967296;
        return 64'd4294967296 * longint'($urandom_range(1, 9)) + longint'($urandom);
    endfunction

    function automatic void push_number(longint unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 7) == 0) push_char(CH_ZERO);
        foreach (s[i]) push_char(t_byte'(s[i]));
    endfunction

    function automatic void push_line(longint unsigned w, longint unsigned h);
        t_byte junk;
        junk = t_byte'($urandom_range(0, 255));
        if (junk == CH_LF) junk = CH_CR;
        repeat ($urandom_range(0, 2)) push_char(pick_blank());
        push_number(w);
        repeat ($urandom_range(1, 3)) push_char(pick_sep());
        push_number(h);
        case ($urandom_range(0, 5))
            0: push_char(CH_NUL);
            1: push_char(pick_sep());
            2: push_char(CH_CR);
            3: push_char(junk);
            default: ;
        endcase
        push_char(CH_LF);
    endfunction

    function automatic void queue_random_line();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            push_line(pick_size(), pick_size());
        end else if (kind < 75) begin
            // overflow the line store, then a fresh size
            repeat ($urandom_range(26, 29)) push_char(pick_blank());
            push_line(pick_size(), pick_size());
        end else if (kind < 85) begin
            if ($urandom_range(0, 1) == 0) push_line(pick_wrap(), pick_size());
            else push_line(pick_size(), pick_wrap());
        end else if (kind < 92) begin
            push_number(pick_size());
            if ($urandom_range(0, 1) == 0) push_char(pick_sep());
            push_char(CH_LF);
        end else begin
            repeat ($urandom_range(1, 12)) push_char(t_byte'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0) push_char(CH_LF);
        end
    endfunction

    // ---------------- config writes ----------------
    task automatic write_limit(t_cfg_idx idx, t_dim val);
        @(posedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_MAX_WIDTH:  lim_max_w = val;
            REG_MAX_HEIGHT: lim_max_h = val;
            REG_MIN_WIDTH:  lim_min_w = val;
            default:        lim_min_h = val;
        endcase
    endtask

    task automatic set_limits(t_dim max_w, t_dim max_h, t_dim min_w, t_dim min_h);
        write_limit(REG_MAX_WIDTH,  max_w);
        write_limit(REG_MAX_HEIGHT, max_h);
        write_limit(REG_MIN_WIDTH,  min_w);
        write_limit(REG_MIN_HEIGHT, min_h);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (byte_q.size() != 0 || rx.valid || awaited_lines.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------- byte source ----------------
    initial begin : byte_sender
        t_stim_row    cur;
        t_line_result r;
        int           burst_left;
        int           gap_left;
        rx.valid   = 1'b0;
        rx.rx_byte = '0;
        cur        = '0;
        burst_left = 0;
        gap_left   = 0;
        forever begin
            @(posedge i_clk);
            if (rx.valid && rx.ready) begin
                r = parse_byte(cur.ch);
                if (cur.fixed) r = cur.want;
                awaited_lines.push_back(r);
            end
            if (i_rst_n && !(rx.valid && !rx.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    rx.valid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    cur = byte_q.pop_front();
                    rx.valid   <= 1'b1;
                    rx.rx_byte <= cur.ch;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    rx.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result sink and checker ----------------
    initial begin : result_sink
        t_line_result want;
        int           hold_left;
        bit           hold_done;
        int           mode;
        int           mode_left;
        int           tick;
        res.ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        mode      = 0;
        mode_left = 40;
        tick      = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res.valid && res.ready) begin
                if (awaited_lines.size() == 0) begin
                    report_mismatch("result with none awaited", 1, 0);
                end else begin
                    want = awaited_lines.pop_front();
                    if (res.line_end !== want.line_end)
                        report_mismatch("line_end", res.line_end, want.line_end);
                    if (res.line_ok !== want.line_ok)
                        report_mismatch("line_ok", res.line_ok, want.line_ok);
                    if (res.out_width !== want.width)
                        report_mismatch("out_width", res.out_width, want.width);
                    if (res.out_height !== want.height)
                        report_mismatch("out_height", res.out_height, want.height);
                end
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else if (!hold_done && results_seen == 160) begin
                // long back-pressure: input must stall while bytes keep coming
                hold_done = 1'b1;
                hold_left = 300;
                res.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 80);
                end else begin
                    mode_left--;
                end
                tick++;
                case (mode)
                    0:       res.ready <= 1'b1;
                    1:       res.ready <= 1'($urandom_range(0, 1));
                    default: res.ready <= (tick % 5) < 3;
                endcase
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin : main_seq
        int target;
        i_rst_n        = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = REG_MAX_WIDTH;
        cfg.data       = '0;
        queued_bytes   = 0;
        results_seen   = 0;
        mismatch_count = 0;
        lim_max_w      = RST_MAX_WIDTH;
        lim_max_h      = RST_MAX_HEIGHT;
        lim_min_w      = RST_MIN_WIDTH;
        lim_min_h      = RST_MIN_HEIGHT;
        clear_line();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) byte_q.push_back(DIRECTED[i]);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                1: set_limits(16'd65535, 16'd65535, 16'd2, 16'd2);
                2: set_limits(16'd2, 16'd2, 16'd2, 16'd2);
                3: set_limits(t_dim'($urandom_range(2, 800)), t_dim'($urandom_range(2, 800)),
                              t_dim'($urandom_range(1000, 65535)),
                              t_dim'($urandom_range(1000, 65535)));
                4: set_limits(t_dim'($urandom_range(2, 65535)), t_dim'($urandom_range(2, 65535)),
                              t_dim'($urandom_range(2, 65535)),
                              t_dim'($urandom_range(2, 65535)));
                5: set_limits(16'd65535, 16'd65535, 16'd65535, 16'd65535);
                default: ;
            endcase
            target = queued_bytes + PHASE_BYTES;
            while (queued_bytes < target) queue_random_line();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rlp_pkg.sv
rtl/rlp_ifs.sv
rtl/resolution_line_parser.sv
test/tb_resolution_line_parser.sv
